// ===== hw/rtl/jsu_pkg.sv =====
// Shared types, codes and a helper function for the JSON string unescaper.
package jsu_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] result_kind;
        logic [2:0] error_code;
        logic       last_of_run;
    } out_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_TEXT = 2'd1,
        MODE_ESC  = 2'd2,
        MODE_HEX  = 2'd3
    } mode_t;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NONE           = 3'd0;
    localparam logic [2:0] ERR_EXPECTED_STR   = 3'd1;
    localparam logic [2:0] ERR_UNTERM_STR     = 3'd2;
    localparam logic [2:0] ERR_UNTERM_ESC     = 3'd3;
    localparam logic [2:0] ERR_INVALID_ESC    = 3'd4;
    localparam logic [2:0] ERR_TRUNC_UNICODE  = 3'd5;
    localparam logic [2:0] ERR_BAD_HEX        = 3'd6;

    localparam logic [7:0] CHR_QUOTE     = 8'h22;
    localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHR_SLASH     = 8'h2F;
    localparam logic [7:0] CHR_B         = 8'h62;
    localparam logic [7:0] CHR_F         = 8'h66;
    localparam logic [7:0] CHR_N         = 8'h6E;
    localparam logic [7:0] CHR_R         = 8'h72;
    localparam logic [7:0] CHR_T         = 8'h74;
    localparam logic [7:0] CHR_U         = 8'h75;

    localparam int MAX_RESULTS = 3;

    // Results produced by one input beat; all of them share kind and error code.
    typedef struct packed {
        logic [1:0]                  count;
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [1:0]                  kind;
        logic [2:0]                  err;
    } dec_t;

    // Bit 4 flags a valid hex digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/jsu_step.sv =====
// Scanner state and per-beat decode of escapes and UTF-8 encoding.
module jsu_step
    import jsu_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  in_t  item,
    input  logic advance,
    output dec_t dec
);

    mode_t       mode_reg, mode_next;
    logic [1:0]  digits_reg, digits_next;
    logic [11:0] acc_reg, acc_next;

    logic [4:0]  hex;
    logic [15:0] code;
    logic [7:0]  c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            digits_reg <= 2'd0;
            acc_reg    <= 12'd0;
        end else if (advance) begin
            mode_reg   <= mode_next;
            digits_reg <= digits_next;
            acc_reg    <= acc_next;
        end
    end

    always_comb begin
        c           = item.in_byte;
        hex         = hex_value(c);
        code        = {acc_reg, hex[3:0]};
        mode_next   = mode_reg;
        digits_next = digits_reg;
        acc_next    = acc_reg;
        dec.count   = 2'd0;
        dec.bytes   = '0;
        dec.kind    = KIND_DATA;
        dec.err     = ERR_NONE;

        case (mode_reg)
            MODE_IDLE: begin
                if (item.end_of_text || c != CHR_QUOTE) begin
                    dec.count = 2'd1;
                    dec.kind  = KIND_ERROR;
                    dec.err   = ERR_EXPECTED_STR;
                end else begin
                    mode_next = MODE_TEXT;
                end
            end
            MODE_TEXT: begin
                if (item.end_of_text) begin
                    dec.count = 2'd1;
                    dec.kind  = KIND_ERROR;
                    dec.err   = ERR_UNTERM_STR;
                    mode_next = MODE_IDLE;
                end else if (c == CHR_QUOTE) begin
                    dec.count = 2'd1;
                    dec.kind  = KIND_DONE;
                    mode_next = MODE_IDLE;
                end else if (c == CHR_BACKSLASH) begin
                    mode_next = MODE_ESC;
                end else begin
                    dec.count    = 2'd1;
                    dec.bytes[0] = c;
                end
            end
            MODE_ESC: begin
                dec.count = 2'd1;
                mode_next = MODE_TEXT;
                if (item.end_of_text) begin
                    dec.kind  = KIND_ERROR;
                    dec.err   = ERR_UNTERM_ESC;
                    mode_next = MODE_IDLE;
                end else begin
                    case (c)
                        CHR_QUOTE:     dec.bytes[0] = CHR_QUOTE;
                        CHR_BACKSLASH: dec.bytes[0] = CHR_BACKSLASH;
                        CHR_SLASH:     dec.bytes[0] = CHR_SLASH;
                        CHR_B:         dec.bytes[0] = 8'h08;
                        CHR_F:         dec.bytes[0] = 8'h0C;
                        CHR_N:         dec.bytes[0] = 8'h0A;
                        CHR_R:         dec.bytes[0] = 8'h0D;
                        CHR_T:         dec.bytes[0] = 8'h09;
                        CHR_U: begin
                            dec.count   = 2'd0;
                            mode_next   = MODE_HEX;
                            digits_next = 2'd0;
                            acc_next    = 12'd0;
                        end
                        default: begin
                            dec.kind  = KIND_ERROR;
                            dec.err   = ERR_INVALID_ESC;
                            mode_next = MODE_IDLE;
                        end
                    endcase
                end
            end
            MODE_HEX: begin
                if (item.end_of_text || !hex[4]) begin
                    dec.count   = 2'd1;
                    dec.kind    = KIND_ERROR;
                    dec.err     = item.end_of_text ? ERR_TRUNC_UNICODE : ERR_BAD_HEX;
                    mode_next   = MODE_IDLE;
                    digits_next = 2'd0;
                    acc_next    = 12'd0;
                end else if (digits_reg == 2'd3) begin
                    mode_next   = MODE_TEXT;
                    digits_next = 2'd0;
                    acc_next    = 12'd0;
                    if (code < 16'h0080) begin
                        dec.count    = 2'd1;
                        dec.bytes[0] = code[7:0];
                    end else if (code < 16'h0800) begin
                        dec.count    = 2'd2;
                        dec.bytes[0] = {3'b110, code[10:6]};
                        dec.bytes[1] = {2'b10, code[5:0]};
                    end else begin
                        dec.count    = 2'd3;
                        dec.bytes[0] = {4'b1110, code[15:12]};
                        dec.bytes[1] = {2'b10, code[11:6]};
                        dec.bytes[2] = {2'b10, code[5:0]};
                    end
                end else begin
                    digits_next = digits_reg + 2'd1;
                    acc_next    = code[11:0];
                end
            end
            default: begin
                mode_next = MODE_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/json_string_unescaper_top.sv =====
// Top level of the JSON string unescaper: input register, decode and result burst register.
//
// The block takes one text byte per beat, holds it in the input register, then decodes it
// into the result burst register. Every input beat gives zero, one, two or three result
// beats; a sustained rate of one input beat per cycle holds while m_ready stays high and
// each gives at most one result. A \u escape that encodes to two or three UTF-8 bytes holds
// the input while the result burst register drains them one per cycle while m_ready is high.
module json_string_unescaper_top
    import jsu_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic                        in_valid_reg;
    in_t                         in_data_reg;
    logic [1:0]                  cnt_reg;
    logic [1:0]                  pos_reg;
    logic [MAX_RESULTS-1:0][7:0] bytes_reg;
    logic [1:0]                  kind_reg;
    logic [2:0]                  err_reg;

    dec_t dec;
    logic last;
    logic advance;

    assign m_valid = (cnt_reg != 2'd0);
    assign last    = (pos_reg == cnt_reg - 2'd1);
    assign advance = in_valid_reg && (!m_valid || (m_ready && last));
    assign s_ready = !in_valid_reg || advance;

    jsu_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (in_data_reg),
        .advance (advance),
        .dec     (dec)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            pos_reg <= 2'd0;
        end else if (advance) begin
            cnt_reg <= dec.count;
            pos_reg <= 2'd0;
        end else if (m_valid && m_ready) begin
            if (last) begin
                cnt_reg <= 2'd0;
                pos_reg <= 2'd0;
            end else begin
                pos_reg <= pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            bytes_reg <= dec.bytes;
            kind_reg  <= dec.kind;
            err_reg   <= dec.err;
        end
    end

    always_comb begin
        m_data.out_byte    = 8'd0;
        case (pos_reg)
            2'd0:    m_data.out_byte = bytes_reg[0];
            2'd1:    m_data.out_byte = bytes_reg[1];
            2'd2:    m_data.out_byte = bytes_reg[2];
            default: m_data.out_byte = 8'd0;
        endcase
        m_data.result_kind = kind_reg;
        m_data.error_code  = err_reg;
        m_data.last_of_run = last;
    end

endmodule
